@@ rtl/sorted_set_insert_delete_member_assert.svh @@
// assertion macros for the sorted set block
// expects clk and rst in the scope of each use
`ifndef SORTED_SET_INSERT_DELETE_MEMBER_ASSERT_SVH
`define SORTED_SET_INSERT_DELETE_MEMBER_ASSERT_SVH

// condition holds at every edge out of reset
`define SSIDM_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define SSIDM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/ssidm_pkg.sv @@
// shared types and codes for the sorted set block
// no dependencies
package ssidm_pkg;

  localparam logic [1:0] KIND_MEMBER = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;

  // command broadcast to every cell
  typedef struct packed {
    logic cmp;
    logic ins;
    logic del;
  } ssidm_ctrl_t;

endpackage

@@ rtl/ssidm_cell.sv @@
// one storage cell of the sorted chain: holds a key, compares it, shifts
// depends on ssidm_pkg
module ssidm_cell #(
  parameter int IDX   = 0,
  parameter int KEY_W = 32,
  parameter int CNT_W = 7
) (
  input  logic                     clk,
  input  ssidm_pkg::ssidm_ctrl_t   ctrl,
  input  logic [CNT_W-1:0]         count,
  input  logic signed [KEY_W-1:0]  key_in,
  input  logic signed [KEY_W-1:0]  left_key,
  input  logic                     left_lt,
  input  logic signed [KEY_W-1:0]  right_key,
  output logic signed [KEY_W-1:0]  key,
  output logic                     lt,
  output logic                     eq
);
  import ssidm_pkg::*;

  logic valid;
  logic signed [KEY_W-1:0] key_next;

  assign valid = CNT_W'(IDX) < count;

  always_comb begin
    key_next = key;
    if (!lt) begin
      if (ctrl.ins) begin
        key_next = (IDX == 0 || left_lt) ? key_in : left_key;
      end else if (ctrl.del) begin
        key_next = right_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
    if (ctrl.cmp) begin
      lt <= valid && (key < key_in);
      eq <= valid && (key == key_in);
    end
  end

endmodule

@@ rtl/sorted_set_insert_delete_member.sv @@
// top level of the sorted set: control sequencer and the chain of cells
// depends on ssidm_pkg, ssidm_cell and sorted_set_insert_delete_member_assert.svh
//
// Keeps up to CAPACITY distinct signed keys in ascending order, one key per
// cell. An operation is accepted when start is high and busy is low; kind 0
// tests membership, 1 inserts, 2 deletes, 3 does nothing. Each operation
// passes through the load, a compare step in which every cell compares its key
// against the broadcast key, and an apply step in which the cells shift toward
// or away from the found position. The result word appears on done_res,
// full_refused and entry_count for exactly one cycle with strobe high; busy
// falls in that same cycle, so a new operation may be started while the
// result is shown. The result cannot be held off and must be taken when
// strobe is high.
module sorted_set_insert_delete_member #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            kind,
  input  logic signed [KEY_WIDTH-1:0]           value,
  output logic                                  strobe,
  output logic                                  done_res,
  output logic                                  full_refused,
  output logic [$clog2(CAPACITY+1)-1:0]         entry_count
);
  import ssidm_pkg::*;

  `include "sorted_set_insert_delete_member_assert.svh"

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {IDLE, CMP, APPLY} state_t;

  state_t                       state;
  logic [1:0]                   kind_q;
  logic signed [KEY_WIDTH-1:0]  key_q;
  logic [CNT_W-1:0]             count;
  logic [CNT_W-1:0]             count_next;
  ssidm_ctrl_t                  ctrl;
  logic                         hit;
  logic                         full;
  logic                         done_next;
  logic                         refused_next;

  logic signed [KEY_WIDTH-1:0]  keys [CAPACITY];
  logic [CAPACITY-1:0]          lts;
  logic [CAPACITY-1:0]          eqs;

  assign hit  = |eqs;
  assign full = count == CNT_W'(CAPACITY);
  assign busy = state != IDLE;

  always_comb begin
    ctrl         = '0;
    count_next   = count;
    done_next    = 1'b0;
    refused_next = 1'b0;
    ctrl.cmp     = state == CMP;
    if (state == APPLY) begin
      unique case (kind_q)
        KIND_MEMBER: begin
          done_next = hit;
        end
        KIND_INSERT: begin
          if (!hit && full) begin
            refused_next = 1'b1;
          end else if (!hit) begin
            ctrl.ins   = 1'b1;
            count_next = count + CNT_W'(1);
            done_next  = 1'b1;
          end
        end
        KIND_DELETE: begin
          if (hit) begin
            ctrl.del   = 1'b1;
            count_next = count - CNT_W'(1);
            done_next  = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      kind_q <= kind;
      key_q  <= value;
    end
    done_res     <= done_next;
    full_refused <= refused_next;
    entry_count  <= count_next;
    if (rst) begin
      state  <= IDLE;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= state == APPLY;
      count  <= count_next;
      unique case (state)
        IDLE:    if (start) state <= CMP;
        CMP:     state <= APPLY;
        APPLY:   state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ssidm_cell #(
      .IDX   (i),
      .KEY_W (KEY_WIDTH),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (count),
      .key_in    (key_q),
      .left_key  (keys[(i == 0) ? 0 : i - 1]),
      .left_lt   (lts[(i == 0) ? 0 : i - 1]),
      .right_key (keys[(i == CAPACITY - 1) ? i : i + 1]),
      .key       (keys[i]),
      .lt        (lts[i]),
      .eq        (eqs[i])
    );
  end

  `SSIDM_ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(CAPACITY), "count above capacity")
  `SSIDM_ASSERT_NEXT(a_result_follows, start && !busy, ##2 strobe, "result not on time")
  `SSIDM_ASSERT_ALWAYS(a_refused_full,
    !(strobe && full_refused) || (!done_res && entry_count == CNT_W'(CAPACITY)),
    "refused insert without full store")
  `SSIDM_ASSERT_ALWAYS(a_strobe_idle, !strobe || !busy, "result shown while busy")

endmodule

@@ test/testbench.sv @@
// self-checking testbench for the sorted set block: membership, insert and delete
// depends on ssidm_pkg and sorted_set_insert_delete_member
// a queue-based model of the set predicts every result word, checked as it leaves
module testbench;
  import ssidm_pkg::*;

  localparam int CAPACITY = 64;
  localparam int KEY_WIDTH = 32;
  localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int KEY_MIN = 32'sh8000_0000;
  localparam int KEY_MAX = 32'sh7fff_ffff;
  localparam int POOL_SIZE = 160;
  localparam int BIAS_SPAN = 250;

  typedef struct packed {
    logic done_res;
    logic full_refused;
    logic [COUNT_WIDTH-1:0] entry_count;
  } set_word_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [1:0] kind;
  logic signed [KEY_WIDTH-1:0] value;
  logic strobe;
  logic done_res;
  logic full_refused;
  logic [COUNT_WIDTH-1:0] entry_count;

  int stored_keys[$];
  set_word_t pending_words[$];
  int key_pool[POOL_SIZE];
  int error_count;
  int idle_pct;
  int random_sent;
  bit insert_bias;

  sorted_set_insert_delete_member #(
    .CAPACITY(CAPACITY),
    .KEY_WIDTH(KEY_WIDTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .value(value),
    .strobe(strobe),
    .done_res(done_res),
    .full_refused(full_refused),
    .entry_count(entry_count)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // applies one operation to the modeled set and returns the word it yields
  function automatic set_word_t apply_set_op(input logic [1:0] op, input int key);
    set_word_t w;
    int pos;
    bit hit;
    pos = 0;
    while (pos < stored_keys.size() && stored_keys[pos] < key) pos++;
    hit = (pos < stored_keys.size()) && (stored_keys[pos] == key);
    w.done_res = 1'b0;
    w.full_refused = 1'b0;
    case (op)
      KIND_MEMBER: begin
        w.done_res = hit;
      end
      KIND_INSERT: begin
        if (!hit) begin
          if (stored_keys.size() >= CAPACITY) begin
            w.full_refused = 1'b1;
          end else begin
            stored_keys.insert(pos, key);
            w.done_res = 1'b1;
          end
        end
      end
      KIND_DELETE: begin
        if (hit) begin
          stored_keys.delete(pos);
          w.done_res = 1'b1;
        end
      end
      default: ;
    endcase
    w.entry_count = COUNT_WIDTH'(stored_keys.size());
    return w;
  endfunction

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_word(input logic [1:0] op, input int key);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      gap = $urandom_range(4, 1);
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    kind = op;
    value = key;
    do @(posedge clk); while (busy);
    pending_words.push_back(apply_set_op(op, key));
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    start = 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin : result_check
    set_word_t want;
    if (!rst && strobe) begin
      if (pending_words.size() == 0) begin
        $display("%0t: result word with none expected: done_res=%0d full_refused=%0d count=%0d",
                 $time, done_res, full_refused, entry_count);
        error_count++;
      end else begin
        want = pending_words.pop_front();
        if (done_res !== want.done_res) begin
          $display("%0t: done_res expected %0d actual %0d", $time, want.done_res, done_res);
          error_count++;
        end
        if (full_refused !== want.full_refused) begin
          $display("%0t: full_refused expected %0d actual %0d", $time, want.full_refused,
                   full_refused);
          error_count++;
        end
        if (entry_count !== want.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, want.entry_count,
                   entry_count);
          error_count++;
        end
      end
    end
  end

  task automatic test_empty_store();
    send_word(KIND_MEMBER, 0);
    send_word(KIND_DELETE, 5);
    send_word(KIND_MEMBER, KEY_MIN);
  endtask

  task automatic test_insert_order();
    send_word(KIND_INSERT, 0);
    send_word(KIND_INSERT, KEY_MAX);
    send_word(KIND_INSERT, KEY_MIN);
    send_word(KIND_INSERT, -1);
    send_word(KIND_INSERT, 1);
    send_word(KIND_INSERT, 100);
    send_word(KIND_INSERT, -100);
    send_word(KIND_MEMBER, KEY_MAX);
    send_word(KIND_MEMBER, KEY_MIN);
  endtask

  task automatic test_duplicates_and_absent();
    send_word(KIND_INSERT, 0);
    send_word(KIND_INSERT, KEY_MIN);
    send_word(KIND_DELETE, 7);
    send_word(KIND_DELETE, KEY_MIN);
    send_word(KIND_DELETE, KEY_MAX);
    send_word(KIND_MEMBER, KEY_MIN);
  endtask

  task automatic test_unused_kind();
    send_word(KIND_UNUSED, 1);
    send_word(KIND_UNUSED, -1);
  endtask

  // fill to capacity, probe the full store, then empty it in random order
  task automatic test_full_store();
    int k;
    while (stored_keys.size() < CAPACITY) send_word(KIND_INSERT, $urandom);
    repeat (6) send_word(KIND_INSERT, $urandom);
    send_word(KIND_INSERT, stored_keys[$urandom_range(CAPACITY - 1)]);
    send_word(KIND_INSERT, stored_keys[0]);
    send_word(KIND_INSERT, stored_keys[CAPACITY - 1]);
    send_word(KIND_MEMBER, stored_keys[$urandom_range(CAPACITY - 1)]);
    k = stored_keys[$urandom_range(CAPACITY - 1)];
    send_word(KIND_DELETE, k);
    send_word(KIND_INSERT, k);
    send_word(KIND_INSERT, KEY_MIN);
    while (stored_keys.size() > 0) begin
      send_word(KIND_DELETE, stored_keys[$urandom_range(stored_keys.size() - 1)]);
    end
  endtask

  // random mix, leaning toward inserts or deletes in long stretches
  task automatic test_random_mix(input int n);
    int sent;
    int roll;
    int key;
    logic [1:0] op;
    sent = 0;
    while (sent < n) begin
      if (random_sent % BIAS_SPAN == 0) insert_bias = !insert_bias;
      roll = $urandom_range(99);
      if (insert_bias) begin
        op = roll < 70 ? KIND_INSERT : roll < 82 ? KIND_DELETE :
             roll < 97 ? KIND_MEMBER : KIND_UNUSED;
      end else begin
        op = roll < 55 ? KIND_DELETE : roll < 75 ? KIND_INSERT :
             roll < 97 ? KIND_MEMBER : KIND_UNUSED;
      end
      if ($urandom_range(99) < 85) key = key_pool[$urandom_range(POOL_SIZE - 1)];
      else key = $urandom;
      if (op != KIND_INSERT && stored_keys.size() > 0 && $urandom_range(1) == 1) begin
        key = stored_keys[$urandom_range(stored_keys.size() - 1)];
      end
      send_word(op, key);
      if (op != KIND_UNUSED) begin
        sent++;
        random_sent++;
      end
    end
  endtask

  task automatic test_drain_pause();
    test_random_mix(20);
    wait_for_results();
    test_random_mix(20);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    kind = KIND_MEMBER;
    value = '0;
    error_count = 0;
    idle_pct = 38;
    random_sent = 0;
    insert_bias = 1'b0;
    key_pool[0] = 0;
    key_pool[1] = -1;
    key_pool[2] = 1;
    key_pool[3] = KEY_MIN;
    key_pool[4] = KEY_MAX;
    for (int i = 5; i < POOL_SIZE; i++) begin
      if (i % 2 == 0) key_pool[i] = $urandom;
      else key_pool[i] = int'($urandom_range(40)) - 20;
    end
    repeat (12) @(negedge clk);
    rst = 1'b0;

    test_empty_store();
    test_insert_order();
    test_duplicates_and_absent();
    test_unused_kind();

    test_random_mix(380);
    test_full_store();
    test_drain_pause();
    idle_pct = 61;
    test_random_mix(330);
    test_full_store();
    idle_pct = 0;
    test_random_mix(300);

    wait_for_results();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("testbench: errors");
    $finish;
  end

endmodule
